[rtl/lpmc_pkg.sv]
package lpmc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CsrRelQuat    = 3'd0;
   localparam logic [2:0] CsrRelShift   = 3'd1;
   localparam logic [2:0] CsrRotAngle   = 3'd2;
   localparam logic [2:0] CsrInvSin     = 3'd3;
   localparam logic [2:0] CsrEndTime    = 3'd4;
   localparam logic [2:0] CsrInvSpan    = 3'd5;
   localparam logic [2:0] CsrMaxRange   = 3'd6;
   localparam logic [2:0] CsrModeFlags  = 3'd7;

   // Register reset values
   localparam logic [63:0] RelQuatReset  = 64'h7FFF_0000_0000_0000;
   localparam logic [19:0] MaxRangeReset = 20'hF_FFFF;

   // Fixed-point constants
   localparam logic [30:0] OneQ30 = 31'h4000_0000;
   localparam logic [30:0] CoefMax = 31'h7FFF_FFFF;

   // Sine series: six Horner steps, divisors taken as exact reciprocal products
   localparam int SineSteps = 6;
   localparam int SineLat   = 2 * SineSteps + 2;
   localparam int SineDivShift [SineSteps] = '{40, 39, 39, 38, 37, 35};
   localparam logic [32:0] SineDivMul [SineSteps] = '{
      33'((66'd1 << 40) / 66'd156 + 66'd1),
      33'((66'd1 << 39) / 66'd110 + 66'd1),
      33'((66'd1 << 39) / 66'd72 + 66'd1),
      33'((66'd1 << 38) / 66'd42 + 66'd1),
      33'((66'd1 << 37) / 66'd20 + 66'd1),
      33'((66'd1 << 35) / 66'd6 + 66'd1)
   };

   // Point fields that ride along the pipeline
   typedef struct packed {
      logic signed [20:0] pos_x;
      logic signed [20:0] pos_y;
      logic signed [20:0] pos_z;
      logic               missing;
      logic [7:0]         intensity;
      logic [63:0]        stamp;
      logic [30:0]        frac;
   } carry_type;

endpackage

[rtl/lpmc_req_if.sv]
interface lpmc_req_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] pos_x;
   logic signed [20:0] pos_y;
   logic signed [20:0] pos_z;
   logic               x_missing;
   logic [7:0]         intensity;
   logic [63:0]        stamp;

   modport source (output valid, pos_x, pos_y, pos_z, x_missing, intensity, stamp,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, x_missing, intensity, stamp,
                 output ready);
endinterface

[rtl/lpmc_rsp_if.sv]
interface lpmc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] out_x;
   logic signed [20:0] out_y;
   logic signed [20:0] out_z;
   logic [7:0]         out_intensity;
   logic [63:0]        out_stamp;
   logic               raw_copy;
   logic               out_missing;

   modport source (output valid, out_x, out_y, out_z, out_intensity, out_stamp, raw_copy,
                   out_missing, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_intensity, out_stamp, raw_copy,
                 out_missing, output ready);
endinterface

[rtl/lpmc_sine.sv]
module lpmc_sine (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] ang,
   output logic [30:0] sine
);
   localparam int Steps = lpmc_pkg::SineSteps;
   localparam int Last  = 2 * Steps;

   logic [30:0] x_ff  [0:Last];
   logic [31:0] x2_ff [0:Last-2];
   logic [31:0] n_ff  [0:Steps-1];
   logic [30:0] r_ff  [0:Steps-1];
   logic [30:0] sine_ff;
   logic [61:0] sq_in;
   logic [61:0] fin_in;

   // Square the angle and delay angle and square alongside the series
   assign sq_in = 62'(ang) * 62'(ang);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= ang;
         x2_ff[0] <= sq_in[61:30];
         for (int k = 1; k <= Last; k++) x_ff[k] <= x_ff[k-1];
         for (int k = 1; k <= Last - 2; k++) x2_ff[k] <= x2_ff[k-1];
      end
   end

   // One Horner step per two stages: multiply by x^2, then divide by constant and subtract from one
   for (genvar i = 0; i < Steps; i++) begin : g_step
      logic [30:0] r_prev;
      logic [62:0] prod;
      logic [64:0] quo;

      if (i == 0) begin : g_first
         assign r_prev = lpmc_pkg::OneQ30;
      end else begin : g_next
         assign r_prev = r_ff[i-1];
      end

      assign prod = 63'(x2_ff[2*i]) * 63'(r_prev);
      assign quo  = 65'(n_ff[i]) * 65'(lpmc_pkg::SineDivMul[i]);

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[i] <= prod[61:30];
            r_ff[i] <= lpmc_pkg::OneQ30 - 31'(quo >> lpmc_pkg::SineDivShift[i]);
         end
      end
   end

   // Final multiply by x
   assign fin_in = 62'(x_ff[Last]) * 62'(r_ff[Steps-1]);

   always_ff @(posedge clock) begin
      if (en) sine_ff <= fin_in[60:30];
   end

   assign sine = sine_ff;
endmodule

[rtl/lidar_point_motion_compensation.sv]
// Moves each lidar point from its capture time to the end of the sweep. One point
// enters per clock while the result port is not stalled; the block is a single
// 25-stage pipeline with a common stall, so the only wait is a stalled result
// port. The sweep fraction comes from a split 64x64 product, the slerp sines from
// a 14-stage Horner series unit (two copies), then the quaternion, rotation matrix
// and matrix-vector product each take their own stages. Points that fall outside
// the range limit are dropped, or copied raw when rotation and organized output are
// both set. Registers are to be written only while no point is in flight.
module lidar_point_motion_compensation (
   input  logic        clock,
   input  logic        reset,
   lpmc_req_if.sink    req_ch,
   lpmc_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   localparam int StgT    = 3;
   localparam int StgAng  = 4;
   localparam int StgSine = StgAng + lpmc_pkg::SineLat;
   localparam int StgMul  = StgSine + 6;

   // Configuration registers
   logic [63:0] rel_quat_ff;
   logic [62:0] rel_shift_ff;
   logic [30:0] rot_angle_ff;
   logic [47:0] inv_sin_ff;
   logic [63:0] end_time_ff;
   logic [63:0] inv_span_ff;
   logic [19:0] range_limit_ff;
   logic [1:0]  mode_flags_ff;

   // Pipeline control and ride-along fields
   logic                 en;
   logic                 vld_ff   [1:StgMul];
   lpmc_pkg::carry_type  carry_ff [1:StgMul];
   lpmc_pkg::carry_type  carry_in;
   lpmc_pkg::carry_type  carry_t_in;

   // Arithmetic stage registers
   logic [63:0]         diff_ff;
   logic [63:0]         pp_ff [4];
   logic [127:0]        full_prod;
   logic [30:0]         frac_in;
   logic [61:0]         a0_prod, a1_prod;
   logic [30:0]         ang0_ff, ang1_ff;
   logic [30:0]         sin_w [2];
   logic [54:0]         cpl_ff [2];
   logic [54:0]         cph_ff [2];
   logic [78:0]         psum [2];
   logic [30:0]         coef_in [2];
   logic [30:0]         coef_ff [2];
   logic signed [31:0]  c1s;
   logic signed [15:0]  qv [4];
   logic signed [47:0]  qp [4];
   logic signed [31:0]  q_in [4];
   logic signed [31:0]  q_ff [4];
   logic signed [63:0]  mp_ff [9];
   logic signed [63:0]  re [9];
   logic signed [35:0]  r_ff [9];
   logic signed [20:0]  pv [3];
   logic signed [20:0]  sh [3];
   logic signed [52:0]  st_prod [3];
   logic signed [56:0]  rp_ff [9];
   logic signed [50:0]  st_ff [3];
   logic signed [59:0]  acc [3];
   logic signed [31:0]  res [3];
   logic signed [32:0]  mag [3];
   logic signed [20:0]  sat [3];
   logic                far;
   logic                comp;
   logic                raw;
   logic                rot;
   logic                org;

   // Result register
   logic               rsp_valid_ff;
   logic signed [20:0] out_x_ff, out_y_ff, out_z_ff;
   logic [7:0]         out_intensity_ff;
   logic [63:0]        out_stamp_ff;
   logic               raw_copy_ff;
   logic               out_missing_ff;

   assign rot = mode_flags_ff[0];
   assign org = mode_flags_ff[1];

   // Decode register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rel_quat_ff    <= lpmc_pkg::RelQuatReset;
         rel_shift_ff   <= '0;
         rot_angle_ff   <= '0;
         inv_sin_ff     <= '0;
         end_time_ff    <= '0;
         inv_span_ff    <= '0;
         range_limit_ff <= lpmc_pkg::MaxRangeReset;
         mode_flags_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lpmc_pkg::CsrRelQuat:   rel_quat_ff    <= csr_wdata;
            lpmc_pkg::CsrRelShift:  rel_shift_ff   <= csr_wdata[62:0];
            lpmc_pkg::CsrRotAngle:  rot_angle_ff   <= csr_wdata[30:0];
            lpmc_pkg::CsrInvSin:    inv_sin_ff     <= csr_wdata[47:0];
            lpmc_pkg::CsrEndTime:   end_time_ff    <= csr_wdata;
            lpmc_pkg::CsrInvSpan:   inv_span_ff    <= csr_wdata;
            lpmc_pkg::CsrMaxRange:  range_limit_ff <= csr_wdata[19:0];
            lpmc_pkg::CsrModeFlags: mode_flags_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Advance everything unless a finished result is held
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      carry_in.pos_x     = req_ch.pos_x;
      carry_in.pos_y     = req_ch.pos_y;
      carry_in.pos_z     = req_ch.pos_z;
      carry_in.missing   = req_ch.x_missing;
      carry_in.intensity = req_ch.intensity;
      carry_in.stamp     = req_ch.stamp;
      carry_in.frac      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= StgMul; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_ch.valid;
         for (int k = 2; k <= StgMul; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff[1] <= carry_in;
         for (int k = 2; k <= StgMul; k++)
            carry_ff[k] <= (k == StgT) ? carry_t_in : carry_ff[k-1];
      end
   end

   // Sweep fraction: time difference, partial products, then combine
   always_comb begin
      full_prod = {64'b0, pp_ff[0]} + ({64'b0, pp_ff[1]} << 32) +
                  ({64'b0, pp_ff[2]} << 32) + {pp_ff[3], 64'b0};
      frac_in = (full_prod[127:64] != '0) ? lpmc_pkg::OneQ30 : {1'b0, full_prod[63:34]};
      carry_t_in      = carry_ff[StgT-1];
      carry_t_in.frac = frac_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff  <= end_time_ff - req_ch.stamp;
         pp_ff[0] <= 64'(diff_ff[31:0])  * 64'(inv_span_ff[31:0]);
         pp_ff[1] <= 64'(diff_ff[31:0])  * 64'(inv_span_ff[63:32]);
         pp_ff[2] <= 64'(diff_ff[63:32]) * 64'(inv_span_ff[31:0]);
         pp_ff[3] <= 64'(diff_ff[63:32]) * 64'(inv_span_ff[63:32]);
      end
   end

   // Slerp angles
   assign a1_prod = 62'(carry_ff[StgT].frac) * 62'(rot_angle_ff);
   assign a0_prod = 62'(lpmc_pkg::OneQ30 - carry_ff[StgT].frac) * 62'(rot_angle_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ang0_ff <= a0_prod[60:30];
         ang1_ff <= a1_prod[60:30];
      end
   end

   lpmc_sine u_sine0 (.clock(clock), .en(en), .ang(ang0_ff), .sine(sin_w[0]));
   lpmc_sine u_sine1 (.clock(clock), .en(en), .ang(ang1_ff), .sine(sin_w[1]));

   // Scale sines by 1/sin(theta) and saturate
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         psum[j] = 79'(cpl_ff[j]) + (79'(cph_ff[j]) << 24);
         if (psum[j][78:64] != '0 || psum[j][63:32] > 32'(lpmc_pkg::CoefMax))
            coef_in[j] = lpmc_pkg::CoefMax;
         else
            coef_in[j] = psum[j][62:32];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            cpl_ff[j]  <= 55'(sin_w[j]) * 55'(inv_sin_ff[23:0]);
            cph_ff[j]  <= 55'(sin_w[j]) * 55'(inv_sin_ff[47:24]);
            coef_ff[j] <= coef_in[j];
         end
      end
   end

   // Interpolated quaternion in Q28
   always_comb begin
      for (int k = 0; k < 4; k++) qv[k] = rel_quat_ff[63-16*k -: 16];
      c1s = (qv[0] > 16'sd0) ? $signed({1'b0, coef_ff[1]}) : -$signed({1'b0, coef_ff[1]});
      for (int k = 0; k < 4; k++) begin
         qp[k]   = c1s * qv[k];
         q_in[k] = 32'(qp[k] >>> 17);
      end
      q_in[0] = q_in[0] + $signed({3'b0, coef_ff[0][30:2]});
   end

   // Quaternion products, then matrix entries
   always_comb begin
      re[0] = (64'sd1 <<< 56) - ((mp_ff[1] + mp_ff[2]) <<< 1);
      re[1] = (mp_ff[3] - mp_ff[8]) <<< 1;
      re[2] = (mp_ff[4] + mp_ff[7]) <<< 1;
      re[3] = (mp_ff[3] + mp_ff[8]) <<< 1;
      re[4] = (64'sd1 <<< 56) - ((mp_ff[0] + mp_ff[2]) <<< 1);
      re[5] = (mp_ff[5] - mp_ff[6]) <<< 1;
      re[6] = (mp_ff[4] - mp_ff[7]) <<< 1;
      re[7] = (mp_ff[5] + mp_ff[6]) <<< 1;
      re[8] = (64'sd1 <<< 56) - ((mp_ff[0] + mp_ff[1]) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) q_ff[k] <= q_in[k];
         mp_ff[0] <= q_ff[1] * q_ff[1];
         mp_ff[1] <= q_ff[2] * q_ff[2];
         mp_ff[2] <= q_ff[3] * q_ff[3];
         mp_ff[3] <= q_ff[1] * q_ff[2];
         mp_ff[4] <= q_ff[1] * q_ff[3];
         mp_ff[5] <= q_ff[2] * q_ff[3];
         mp_ff[6] <= q_ff[0] * q_ff[1];
         mp_ff[7] <= q_ff[0] * q_ff[2];
         mp_ff[8] <= q_ff[0] * q_ff[3];
         for (int k = 0; k < 9; k++) r_ff[k] <= re[k][63:28];
      end
   end

   // Rotate the point and scale the shift
   always_comb begin
      pv[0] = carry_ff[StgMul-1].pos_x;
      pv[1] = carry_ff[StgMul-1].pos_y;
      pv[2] = carry_ff[StgMul-1].pos_z;
      for (int i = 0; i < 3; i++) begin
         sh[i]      = rel_shift_ff[62-21*i -: 21];
         st_prod[i] = sh[i] * $signed({1'b0, carry_ff[StgMul-1].frac});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) rp_ff[3*i+j] <= r_ff[3*i+j] * pv[j];
            st_ff[i] <= st_prod[i][52:2];
         end
      end
   end

   // Sum, round to mm, check range and pick compensated, raw or drop
   always_comb begin
      far = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (rot)
            acc[i] = 60'(rp_ff[3*i]) + 60'(rp_ff[3*i+1]) + 60'(rp_ff[3*i+2]) + 60'(st_ff[i]);
         else
            acc[i] = 60'(i == 0 ? carry_ff[StgMul].pos_x :
                          i == 1 ? carry_ff[StgMul].pos_y : carry_ff[StgMul].pos_z)
                     * 60'sd268435456 + 60'(st_ff[i]);
         res[i] = 32'((acc[i] + 60'sd134217728) >>> 28);
         mag[i] = res[i][31] ? -33'(res[i]) : 33'(res[i]);
         if (mag[i] > $signed({13'b0, range_limit_ff})) far = 1'b1;
         if (res[i] > 32'sd1048575)
            sat[i] = 21'sd1048575;
         else if (res[i] < -32'sd1048576)
            sat[i] = -21'sd1048576;
         else
            sat[i] = res[i][20:0];
      end
      comp = !carry_ff[StgMul].missing && !far;
      raw  = !comp && rot && org;
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[StgMul] && (comp || raw);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff         <= comp ? sat[0] : carry_ff[StgMul].pos_x;
         out_y_ff         <= comp ? sat[1] : carry_ff[StgMul].pos_y;
         out_z_ff         <= comp ? sat[2] : carry_ff[StgMul].pos_z;
         out_intensity_ff <= carry_ff[StgMul].intensity;
         out_stamp_ff     <= carry_ff[StgMul].stamp;
         raw_copy_ff      <= !comp;
         out_missing_ff   <= !comp && carry_ff[StgMul].missing;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_x         = out_x_ff;
   assign rsp_ch.out_y         = out_y_ff;
   assign rsp_ch.out_z         = out_z_ff;
   assign rsp_ch.out_intensity = out_intensity_ff;
   assign rsp_ch.out_stamp     = out_stamp_ff;
   assign rsp_ch.raw_copy      = raw_copy_ff;
   assign rsp_ch.out_missing   = out_missing_ff;

   // Compensated points stay inside the allowed range in x
   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.raw_copy |->
         ($signed(rsp_ch.out_x) <= $signed({2'b0, range_limit_ff})) &&
         ($signed(rsp_ch.out_x) >= -$signed({2'b0, range_limit_ff})))
      else $error("compensated x beyond range limit");

   // Raw copies only under rotation with organized output
   a_raw_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.raw_copy |-> mode_flags_ff == 2'b11)
      else $error("raw copy outside organized rotation mode");

   // A missing flag is only reported on a raw copy
   a_missing_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_missing |-> rsp_ch.raw_copy)
      else $error("missing flag on compensated point");
endmodule

[dv/tb.sv]
module tb;

   typedef struct {
      logic signed [20:0] pos_x;
      logic signed [20:0] pos_y;
      logic signed [20:0] pos_z;
      logic               missing;
      logic [7:0]         intensity;
      logic [63:0]        stamp;
   } point_type;

   typedef struct {
      logic signed [20:0] out_x;
      logic signed [20:0] out_y;
      logic signed [20:0] out_z;
      logic [7:0]         out_intensity;
      logic [63:0]        out_stamp;
      logic               raw_copy;
      logic               out_missing;
   } comp_point_type;

   localparam longint ONE_Q30 = longint'(1) <<< 30;
   localparam longint unsigned COEF_SAT = 64'h7FFF_FFFF;
   localparam int STEP_COUNT = 12;
   localparam int POINTS_PER_STEP = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   // Slerp motion compensation predictor with its own register copies
   class point_scoreboard;
      logic [63:0]    quat;
      logic [62:0]    shift;
      logic [30:0]    angle;
      logic [47:0]    inv_sin;
      logic [63:0]    sweep_end;
      logic [63:0]    span_inv;
      logic [19:0]    range_max;
      logic [1:0]     mode;
      comp_point_type pending_points[$];
      int             errors;

      function new();
         quat = lpmc_pkg::RelQuatReset;
         shift = '0;
         angle = '0;
         inv_sin = '0;
         sweep_end = '0;
         span_inv = '0;
         range_max = lpmc_pkg::MaxRangeReset;
         mode = '0;
         errors = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [63:0] v);
         case (idx)
            lpmc_pkg::CsrRelQuat:   quat = v;
            lpmc_pkg::CsrRelShift:  shift = v[62:0];
            lpmc_pkg::CsrRotAngle:  angle = v[30:0];
            lpmc_pkg::CsrInvSin:    inv_sin = v[47:0];
            lpmc_pkg::CsrEndTime:   sweep_end = v;
            lpmc_pkg::CsrInvSpan:   span_inv = v;
            lpmc_pkg::CsrMaxRange:  range_max = v[19:0];
            lpmc_pkg::CsrModeFlags: mode = v[1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned sine_q30(longint unsigned x);
         longint unsigned x2, r;
         longint unsigned divs[6];
         divs = '{156, 110, 72, 42, 20, 6};
         x2 = (x * x) >> 30;
         r = ONE_Q30;
         for (int i = 0; i < 6; i++)
            r = ONE_Q30 - ((x2 * r) >> 30) / divs[i];
         return (x * r) >> 30;
      endfunction

      function longint slerp_coef(longint unsigned s);
         logic [127:0] prod;
         prod = s * inv_sin;
         if (prod[127:64] != 0) return longint'(COEF_SAT);
         if (prod[63:32] > COEF_SAT) return longint'(COEF_SAT);
         return longint'(prod[63:32]);
      endfunction

      function logic signed [20:0] clamp21(longint v);
         if (v > 1048575) v = 1048575;
         if (v < -1048576) v = -1048576;
         return v[20:0];
      endfunction

      // Work out the compensated point, or a raw copy; 0 when the point is dropped
      function bit compensate(input point_type p, output comp_point_type r);
         longint px[3], sh[3], res[3], q[4], m[9];
         longint t, c0, c1, acc, mag, one;
         longint unsigned a0, a1;
         logic [63:0] dt;
         logic [127:0] prod;
         bit valid;
         px[0] = p.pos_x;
         px[1] = p.pos_y;
         px[2] = p.pos_z;
         for (int i = 0; i < 3; i++)
            sh[i] = longint'($signed(shift[62-21*i -: 21]));
         r.out_intensity = p.intensity;
         r.out_stamp = p.stamp;
         valid = 1'b1;
         if (!p.missing) begin
            dt = sweep_end - p.stamp;
            prod = dt * span_inv;
            t = (prod[127:64] != 0) ? ONE_Q30 : longint'(prod[63:34]);
            if (mode[0]) begin
               a1 = (longint'(t) * longint'(angle)) >> 30;
               a0 = ((ONE_Q30 - t) * longint'(angle)) >> 30;
               c0 = slerp_coef(sine_q30(a0));
               c1 = slerp_coef(sine_q30(a1));
               if ($signed(quat[63:48]) <= 0) c1 = -c1;
               for (int i = 0; i < 4; i++)
                  q[i] = (c1 * longint'($signed(quat[63-16*i -: 16]))) >>> 17;
               q[0] += c0 >>> 2;
               one = longint'(1) <<< 56;
               m[0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
               m[1] = 2 * (q[1] * q[2] - q[0] * q[3]);
               m[2] = 2 * (q[1] * q[3] + q[0] * q[2]);
               m[3] = 2 * (q[1] * q[2] + q[0] * q[3]);
               m[4] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
               m[5] = 2 * (q[2] * q[3] - q[0] * q[1]);
               m[6] = 2 * (q[1] * q[3] - q[0] * q[2]);
               m[7] = 2 * (q[2] * q[3] + q[0] * q[1]);
               m[8] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
               for (int i = 0; i < 9; i++)
                  m[i] = m[i] >>> 28;
               for (int i = 0; i < 3; i++) begin
                  acc = m[3*i] * px[0] + m[3*i+1] * px[1] + m[3*i+2] * px[2] +
                        ((sh[i] * t) >>> 2);
                  res[i] = (acc + (longint'(1) <<< 27)) >>> 28;
               end
            end else begin
               for (int i = 0; i < 3; i++)
                  res[i] = ((px[i] <<< 28) + ((sh[i] * t) >>> 2) +
                            (longint'(1) <<< 27)) >>> 28;
            end
            for (int i = 0; i < 3; i++) begin
               mag = (res[i] < 0) ? -res[i] : res[i];
               if (mag > longint'(range_max)) valid = 1'b0;
            end
            if (valid) begin
               r.out_x = clamp21(res[0]);
               r.out_y = clamp21(res[1]);
               r.out_z = clamp21(res[2]);
               r.raw_copy = 1'b0;
               r.out_missing = 1'b0;
               return 1'b1;
            end
         end
         // Organized rotation output keeps the point raw
         if (mode == 2'b11) begin
            r.out_x = p.pos_x;
            r.out_y = p.pos_y;
            r.out_z = p.pos_z;
            r.raw_copy = 1'b1;
            r.out_missing = p.missing;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_point(point_type p);
         comp_point_type r;
         if (compensate(p, r)) pending_points.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(comp_point_type a);
         comp_point_type e;
         if (pending_points.size() == 0) begin
            $error("result transfer with nothing pending");
            errors++;
            return;
         end
         e = pending_points.pop_front();
         compare_field("out_x", 64'(e.out_x), 64'(a.out_x));
         compare_field("out_y", 64'(e.out_y), 64'(a.out_y));
         compare_field("out_z", 64'(e.out_z), 64'(a.out_z));
         compare_field("out_intensity", 64'(e.out_intensity), 64'(a.out_intensity));
         compare_field("out_stamp", e.out_stamp, a.out_stamp);
         compare_field("raw_copy", 64'(e.raw_copy), 64'(a.raw_copy));
         compare_field("out_missing", 64'(e.out_missing), 64'(a.out_missing));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   bit          quiet;
   int          cycles;
   logic [63:0] sweep_span;
   point_scoreboard sb;

   lpmc_req_if req_ch();
   lpmc_rsp_if rsp_ch();

   lidar_point_motion_compensation u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Note every transfer on both channels, sampled before the edge updates
   always @(posedge clock) begin
      point_type p;
      comp_point_type r;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            p.pos_x = req_ch.pos_x;
            p.pos_y = req_ch.pos_y;
            p.pos_z = req_ch.pos_z;
            p.missing = req_ch.x_missing;
            p.intensity = req_ch.intensity;
            p.stamp = req_ch.stamp;
            sb.note_point(p);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            r.out_x = rsp_ch.out_x;
            r.out_y = rsp_ch.out_y;
            r.out_z = rsp_ch.out_z;
            r.out_intensity = rsp_ch.out_intensity;
            r.out_stamp = rsp_ch.out_stamp;
            r.raw_copy = rsp_ch.raw_copy;
            r.out_missing = rsp_ch.out_missing;
            sb.check_result(r);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stall the result port in short random bursts
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_register(idx, v);
      @(posedge clock);
   endtask

   // Hold valid until the transfer, with an optional gap before it
   task automatic send_point(point_type p);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= p.pos_x;
      req_ch.pos_y <= p.pos_y;
      req_ch.pos_z <= p.pos_z;
      req_ch.x_missing <= p.missing;
      req_ch.intensity <= p.intensity;
      req_ch.stamp <= p.stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [20:0] clamp_mm(real v);
      if (v > 1048575.0) return 21'h0F_FFFF;
      if (v < -1048576.0) return 21'h10_0000;
      return 21'($rtoi(v));
   endfunction

   function automatic logic [15:0] to_q15(real v);
      longint k;
      k = longint'(v * 32768.0);
      if (k > 32767) k = 32767;
      if (k < -32768) k = -32768;
      return k[15:0];
   endfunction

   // Load a sweep pose: rotation by theta about a random axis, random shift
   task automatic setup_step(int step);
      real th, ax, ay, az, nrm, s, inv_s, sgn;
      logic [63:0] quat, shift, angle, inv_sin, span_inv, sweep_end;
      logic [127:0] quot;
      logic [19:0] rng;
      logic [1:0] mode;
      mode = 2'(step % 4);
      if (step == 1) mode = 2'b11;
      th = 0.05 + 1.5 * $urandom_range(0, 1000) / 1000.0;
      if (step == 5) th = 1686629713.0 / 1073741824.0;
      ax = $urandom_range(0, 2000) - 1000.0;
      ay = $urandom_range(0, 2000) - 1000.0;
      az = $urandom_range(0, 2000) - 1000.0 + 1.0;
      nrm = $sqrt(ax * ax + ay * ay + az * az);
      s = $sin(th);
      sgn = (step == 7 || step == 10) ? -1.0 : 1.0;
      quat = {to_q15(sgn * $cos(th)), to_q15(sgn * s * ax / nrm),
              to_q15(sgn * s * ay / nrm), to_q15(sgn * s * az / nrm)};
      angle = 64'($rtoi(th * 1073741824.0 / 4.0)) << 2;
      inv_s = 4294967296.0 / s;
      inv_sin = (inv_s > 2.8e14) ? 64'hFFFF_FFFF_FFFF : 64'(longint'(inv_s));
      if (step == 4) begin
         quat = lpmc_pkg::RelQuatReset;
         angle = '0;
         inv_sin = 64'hFFFF_FFFF_FFFF;
      end
      shift = {1'b0, clamp_mm($urandom_range(0, 100000) - 50000.0),
               clamp_mm($urandom_range(0, 100000) - 50000.0),
               clamp_mm($urandom_range(0, 100000) - 50000.0)};
      sweep_span = 64'($urandom_range(1000, 100000000));
      quot = (128'd1 << 64) / sweep_span;
      span_inv = quot[63:0];
      if (step == 6) span_inv = '0;
      if (step == 7) span_inv = '1;
      sweep_end = {$urandom(), $urandom()};
      rng = 20'($urandom_range(100000, 400000));
      if (step == 5) rng = '0;
      if (step == 8) rng = lpmc_pkg::MaxRangeReset;
      write_reg(lpmc_pkg::CsrRelQuat, quat);
      write_reg(lpmc_pkg::CsrRelShift, shift);
      write_reg(lpmc_pkg::CsrRotAngle, angle);
      write_reg(lpmc_pkg::CsrInvSin, inv_sin);
      write_reg(lpmc_pkg::CsrEndTime, sweep_end);
      write_reg(lpmc_pkg::CsrInvSpan, span_inv);
      write_reg(lpmc_pkg::CsrMaxRange, 64'(rng));
      write_reg(lpmc_pkg::CsrModeFlags, 64'(mode));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic point_type make_point();
      point_type p;
      int kind;
      kind = $urandom_range(0, 9);
      p.intensity = 8'($urandom());
      if (kind == 0) begin
         // noise: every field at random over its whole width
         p.pos_x = 21'($urandom());
         p.pos_y = 21'($urandom());
         p.pos_z = 21'($urandom());
         p.missing = 1'($urandom());
         p.stamp = {$urandom(), $urandom()};
      end else begin
         p.pos_x = 21'($urandom_range(0, 600000) - 300000);
         p.pos_y = 21'($urandom_range(0, 600000) - 300000);
         p.pos_z = 21'($urandom_range(0, 200000) - 100000);
         p.missing = (kind == 1);
         p.stamp = sb.sweep_end - 64'($urandom_range(0, 32'(sweep_span)));
         if (kind == 2) p.stamp = sb.sweep_end + 64'($urandom_range(1, 100000));
      end
      return p;
   endfunction

   task automatic send_directed();
      point_type p;
      for (int i = 0; i < 12; i++) begin
         p.pos_x = (i % 3 == 0) ? 21'h0F_FFFF : (i % 3 == 1) ? 21'h10_0000 : 21'd0;
         p.pos_y = (i % 2 == 0) ? 21'h10_0000 : 21'h0F_FFFF;
         p.pos_z = (i < 6) ? 21'h0F_FFFF : 21'h10_0000;
         if (i >= 8) begin
            p.pos_x = 21'(i * 1000);
            p.pos_y = -21'(i * 700);
            p.pos_z = 21'd5;
         end
         p.missing = (i == 2 || i == 9);
         p.intensity = (i % 2 == 0) ? 8'hFF : 8'h00;
         p.stamp = (i % 4 == 0) ? 64'd0 : (i % 4 == 1) ? '1 :
                   (i % 4 == 2) ? sb.sweep_end : sb.sweep_end - (sweep_span >> 1);
         send_point(p);
      end
   endtask

   initial begin
      sb = new();
      quiet = 1'b0;
      sweep_span = 64'd1000;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= lpmc_pkg::CsrRelQuat;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.pos_z <= '0;
      req_ch.x_missing <= 1'b0;
      req_ch.intensity <= '0;
      req_ch.stamp <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under reset settings, then under organized rotation
      send_directed();
      drain();
      setup_step(1);
      send_directed();
      drain();

      // Random sweeps across modes and extreme settings; last one without idling
      for (int step = 2; step < STEP_COUNT; step++) begin
         setup_step(step);
         if (step == STEP_COUNT - 1) quiet = 1'b1;
         for (int n = 0; n < POINTS_PER_STEP + 25 * (step % 3); n++)
            send_point(make_point());
         drain();
      end

      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
